/* hdl/cilp_pkg.sv */
// shared constants for the c integer literal parser
package cilp_pkg;

   // default accumulator width and fixed result width
   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int RESULT_WIDTH        = 32;

   // stream payload widths
   localparam int REQ_TDATA_WIDTH = 8;
   localparam int RSP_TDATA_WIDTH = 40;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_UP_L  = 8'h4c;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_LO_L  = 8'h6c;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;

   // value of a letter hex digit is its offset plus ten
   localparam logic [7:0] HEX_LETTER_BASE = 8'h0a;

endpackage

/* hdl/c_integer_literal_parser.sv */
// c integer literal parser: one character per transaction, one result per literal
// a character is registered in the input register, then processed from it; the result of
// a nul is registered in the result register and shows on rsp from there
// throughput: one character per cycle, set by the shift-and-add accumulate step; a nul is held while a result waits
// reset: synchronous, active high; clears phase, accumulator and both valid flags
module c_integer_literal_parser
   import cilp_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: [7:0] char_in
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // rsp_tdata: [31:0] value, [32] error, [39:33] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      PH_START,
      PH_ZERO,
      PH_DEC,
      PH_OCT,
      PH_HEX,
      PH_SUFFIX,
      PH_ERR
   } phase_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff, char_in;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] value_ff, value_in;
   logic                    error_ff, error_in;

   // decode signals
   logic                          is_nul, is_dec, is_oct, is_suffix, is_x;
   logic                          is_hex_lo, is_hex_up;
   logic [7:0]                    hex_code;
   logic [3:0]                    digit;
   logic [VALUE_WIDTH-1:0]        digit_ext, acc_dec, acc_oct, acc_hex;
   logic [VALUE_WIDTH+RESULT_WIDTH-1:0] acc_wide;
   logic                          proc;

   // character classes
   assign is_nul    = (char_ff == CHAR_NUL);
   assign is_dec    = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign is_oct    = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_SEVEN);
   assign is_hex_lo = (char_ff >= CHAR_LO_A) && (char_ff <= CHAR_LO_F);
   assign is_hex_up = (char_ff >= CHAR_UP_A) && (char_ff <= CHAR_UP_F);
   assign is_suffix = (char_ff == CHAR_LO_L) || (char_ff == CHAR_UP_L);
   assign is_x      = (char_ff == CHAR_LO_X) || (char_ff == CHAR_UP_X);

   // digit value for any radix
   always_comb begin
      hex_code = char_ff - CHAR_ZERO;
      if (is_hex_lo) begin
         hex_code = char_ff - CHAR_LO_A + HEX_LETTER_BASE;
      end else if (is_hex_up) begin
         hex_code = char_ff - CHAR_UP_A + HEX_LETTER_BASE;
      end
   end
   assign digit     = hex_code[3:0];
   assign digit_ext = {{(VALUE_WIDTH-4){1'b0}}, digit};

   // shift-and-add accumulate, wrapping at the accumulator width
   assign acc_dec = (acc_ff << 3) + (acc_ff << 1) + digit_ext;
   assign acc_oct = (acc_ff << 3) + digit_ext;
   assign acc_hex = (acc_ff << 4) + digit_ext;

   // accumulator cut or extended to the result width
   assign acc_wide = {{RESULT_WIDTH{1'b0}}, acc_ff};

   // the held character advances unless it is a nul blocked by a full result register
   assign proc       = in_valid_ff && (!is_nul || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;

   // next state
   always_comb begin
      in_valid_in  = in_valid_ff && !proc;
      char_in      = char_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      value_in     = value_ff;
      error_in     = error_ff;

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         char_in     = req_tdata;
      end

      if (proc) begin
         if (is_nul) begin
            // end of literal: emit result and restart
            rsp_valid_in = 1'b1;
            error_in     = (phase_ff == PH_START) || (phase_ff == PH_ERR);
            value_in     = ((phase_ff == PH_START) || (phase_ff == PH_ERR)) ?
                           '0 : acc_wide[RESULT_WIDTH-1:0];
            phase_in     = PH_START;
            acc_in       = '0;
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  acc_in = '0;
                  if (char_ff == CHAR_ZERO) begin
                     phase_in = PH_ZERO;
                  end else if (is_dec) begin
                     acc_in   = digit_ext;
                     phase_in = PH_DEC;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_ZERO, PH_OCT: begin
                  if ((phase_ff == PH_ZERO) && is_x) begin
                     phase_in = PH_HEX;
                  end else if (is_oct) begin
                     acc_in   = acc_oct;
                     phase_in = PH_OCT;
                  end else begin
                     phase_in = is_suffix ? PH_SUFFIX : PH_ERR;
                  end
               end
               PH_DEC: begin
                  if (is_dec) begin
                     acc_in = acc_dec;
                  end else begin
                     phase_in = is_suffix ? PH_SUFFIX : PH_ERR;
                  end
               end
               PH_HEX: begin
                  if (is_dec || is_hex_lo || is_hex_up) begin
                     acc_in = acc_hex;
                  end else begin
                     phase_in = is_suffix ? PH_SUFFIX : PH_ERR;
                  end
               end
               default: begin
                  phase_in = PH_ERR;
               end
            endcase
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      value_ff <= value_in;
      error_ff <= error_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-RESULT_WIDTH-1){1'b0}}, error_ff, value_ff};

`ifndef ASSERT_OFF
   // an error result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!error_ff || (value_ff == '0)))
      else $error("error result with nonzero value");

   // a processed nul returns the parser to its start phase with a clear accumulator
   assert property (@(posedge clock) disable iff (reset)
      (proc && is_nul) |=> ((phase_ff == PH_START) && (acc_ff == '0) && rsp_valid_ff))
      else $error("parser not restarted after end of literal");

   // the start phase always holds a clear accumulator
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_START) |-> (acc_ff == '0))
      else $error("accumulator not clear in start phase");

   // an empty input register always takes a character
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stalled while input register empty");
`endif

endmodule
